// ===== design/uvs_pkg.sv =====
// uvs_pkg: shared types, constants and the Q2.14 sine table for the UV-sphere ring tessellator.
// Used by uvs_mac and uv_sphere_ring_tessellator. No dependencies.
`default_nettype none

package uvs_pkg;

	localparam int L = 16;                       // sphere fineness
	localparam int JW = $clog2(L);               // longitude counter
	localparam int TW = $clog2(5 * L);           // trig angle index, units of pi/(2L)
	localparam int QW = $clog2(L + 1);           // quarter-wave table index
	localparam int TRIG_W = 16;                  // Q2.14
	localparam int TRIG_FRAC = 14;
	localparam int POS_W = 32;
	localparam int RADIUS_W = 31;
	localparam int COLOR_W = 8;
	localparam int IDX_W = 32;
	localparam int RING_W = 5;

	localparam int MA_W = 47;                    // holds radius * sin(theta)
	localparam int MB_W = TRIG_W;
	localparam int PROD_W = MA_W + MB_W;
	localparam int RND_W = 47;

	localparam logic KIND_VERTEX = 1'b0;
	localparam logic KIND_TRI = 1'b1;

	localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

	// |sin(pi*n/(2L))| for n = 0..L, Q2.14 rounded half up; table is for L = 16
	localparam logic signed [TRIG_W-1:0] QSIN [0:L] = '{
		16'sd0, 16'sd1606, 16'sd3196, 16'sd4756, 16'sd6270, 16'sd7723,
		16'sd9102, 16'sd10394, 16'sd11585, 16'sd12665, 16'sd13623, 16'sd14449,
		16'sd15137, 16'sd15679, 16'sd16069, 16'sd16305, 16'sd16384
	};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_ST,
		ST_MUL_CT,
		ST_WAIT_HDR,
		ST_MUL_X,
		ST_MUL_Z,
		ST_WAIT_V,
		ST_EMIT_V,
		ST_TRI
	} seq_state_t;

	typedef enum logic [1:0] {
		TAG_RS,
		TAG_PY,
		TAG_PX,
		TAG_PZ
	} mac_tag_t;

	typedef enum logic [1:0] {
		SH_NONE,
		SH_TRIG,
		SH_TRIG2
	} shift_t;

	typedef struct packed {
		logic                     valid;
		mac_tag_t                 tag;
		shift_t                   sh;
		logic signed [MA_W-1:0]   a;
		logic signed [MB_W-1:0]   b;
		logic signed [POS_W-1:0]  c;
	} mac_op_t;

	typedef struct packed {
		logic                     valid;
		mac_tag_t                 tag;
		logic signed [RND_W-1:0]  value;
	} mac_rnd_t;

	typedef struct packed {
		logic                     valid;
		mac_tag_t                 tag;
		logic signed [POS_W-1:0]  value;
	} mac_sum_t;

	typedef struct packed {
		logic signed [POS_W-1:0]  center_x;
		logic signed [POS_W-1:0]  center_y;
		logic signed [POS_W-1:0]  center_z;
		logic [RADIUS_W-1:0]      sphere_radius;
		logic [COLOR_W-1:0]       color_red;
		logic [COLOR_W-1:0]       color_green;
		logic [COLOR_W-1:0]       color_blue;
		logic [IDX_W-1:0]         base_vertex;
		logic [RING_W-1:0]        ring;
	} sphere_item_t;

	typedef struct packed {
		logic                     item_kind;
		logic signed [POS_W-1:0]  pos_x;
		logic signed [POS_W-1:0]  pos_y;
		logic signed [POS_W-1:0]  pos_z;
		logic [COLOR_W-1:0]       out_red;
		logic [COLOR_W-1:0]       out_green;
		logic [COLOR_W-1:0]       out_blue;
		logic [IDX_W-1:0]         index_a;
		logic [IDX_W-1:0]         index_b;
		logic [IDX_W-1:0]         index_c;
		logic                     last;
	} prim_item_t;

	// sin(pi*n/(2L)) in Q2.14, n below 5L
	function automatic logic signed [TRIG_W-1:0] trig_q14(input logic [TW-1:0] n);
		logic [TW-1:0] m;
		logic neg;
		logic signed [TRIG_W-1:0] v;
		m = n;
		neg = 1'b0;
		if (m >= TW'(4 * L)) m = m - TW'(4 * L);
		if (m >= TW'(2 * L)) begin
			neg = 1'b1;
			m = m - TW'(2 * L);
		end
		if (m > TW'(L)) m = TW'(2 * L) - m;
		v = QSIN[m[QW-1:0]];
		return neg ? -v : v;
	endfunction

endpackage

`default_nettype wire

// ===== design/uvs_mac.sv =====
// uvs_mac: shared multiply, round and saturating-add unit, three register stages.
// Depends on uvs_pkg.
`default_nettype none

module uvs_mac
	import uvs_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire mac_op_t  op,
	output mac_rnd_t      rnd,
	output mac_sum_t      sum
);

	logic signed [MA_W-1:0]   mul_a;
	logic signed [MB_W-1:0]   mul_b;
	logic signed [PROD_W-1:0] prod;

	logic                     valid_s1, valid_s2, valid_s3;
	mac_tag_t                 tag_s1, tag_s2, tag_s3;
	shift_t                   sh_s1;
	logic signed [POS_W-1:0]  c_s1, c_s2;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [RND_W-1:0]  rnd_s2;
	logic signed [POS_W-1:0]  sum_s3;

	logic signed [PROD_W-1:0] bias, biased, shifted;
	logic signed [RND_W-1:0]  rnd_d;
	logic signed [RND_W:0]    wide;
	logic [RND_W-POS_W+1:0]   hi;
	logic signed [POS_W-1:0]  sum_d;

	assign mul_a = op.a;
	assign mul_b = op.b;
	assign prod = mul_a * mul_b;

	// round to nearest, ties away from zero
	always_comb begin
		bias = '0;
		case (sh_s1)
			SH_TRIG: begin
				bias = prod_s1[PROD_W-1] ? (PROD_W'(1) << (TRIG_FRAC - 1)) - PROD_W'(1)
				                         : (PROD_W'(1) << (TRIG_FRAC - 1));
			end
			SH_TRIG2: begin
				bias = prod_s1[PROD_W-1] ? (PROD_W'(1) << (2 * TRIG_FRAC - 1)) - PROD_W'(1)
				                         : (PROD_W'(1) << (2 * TRIG_FRAC - 1));
			end
			default: bias = '0;
		endcase
		biased = prod_s1 + bias;
		case (sh_s1)
			SH_TRIG:  shifted = biased >>> TRIG_FRAC;
			SH_TRIG2: shifted = biased >>> (2 * TRIG_FRAC);
			default:  shifted = biased;
		endcase
		rnd_d = shifted[RND_W-1:0];
	end

	always_comb begin
		wide = {{(RND_W+1-POS_W){c_s2[POS_W-1]}}, c_s2} + {rnd_s2[RND_W-1], rnd_s2};
		hi = wide[RND_W:POS_W-1];
		if (hi == '0 || hi == '1) begin
			sum_d = wide[POS_W-1:0];
		end else begin
			sum_d = wide[RND_W] ? POS_MIN : POS_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= op.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1 <= op.tag;
		sh_s1 <= op.sh;
		c_s1 <= op.c;
		prod_s1 <= prod;
		tag_s2 <= tag_s1;
		c_s2 <= c_s1;
		rnd_s2 <= rnd_d;
		tag_s3 <= tag_s2;
		sum_s3 <= sum_d;
	end

	assign rnd.valid = valid_s2;
	assign rnd.tag = tag_s2;
	assign rnd.value = rnd_s2;
	assign sum.valid = valid_s3;
	assign sum.tag = tag_s3;
	assign sum.value = sum_s3;

endmodule

`default_nettype wire

// ===== design/uv_sphere_ring_tessellator.sv =====
// uv_sphere_ring_tessellator: sequencer, trig lookup, index generation and output register.
// Depends on uvs_pkg and uvs_mac.
//
// One request names a sphere and one latitude ring; the block returns that ring's vertices and
// then the triangles joining it to the ring above, the final item flagged by last. Requests are
// taken one at a time: sphere_stall stays high from acceptance until the last result has been
// loaded into the output register, which then waits on prim_stall while the next request is
// taken. All products go through a single multiplier followed by a rounding stage and a
// saturating add stage. A band ring runs: accept, the ring header (r*sin, r*cos), then for
// each vertex two products, the wait through the pipeline and one load, and then its 2L
// triangles; ring 1 has only L cap triangles. A pole ring gives a single vertex, and the
// south pole then its L cap triangles. Rings above L are accepted and give no results.
// While prim_stall holds a result, the next vertex load or triangle waits.
`default_nettype none

module uv_sphere_ring_tessellator
	import uvs_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          sphere_valid,
	output logic               sphere_stall,
	input  wire sphere_item_t  sphere,
	output logic               prim_valid,
	input  wire logic          prim_stall,
	output prim_item_t         prim
);

	seq_state_t               state_q, state_d;
	sphere_item_t             in_q;
	logic [JW-1:0]            j_q, jn;
	logic                     half_q;
	logic [IDX_W-1:0]         cur_q, prev_q;
	logic signed [MA_W-1:0]   rs_q;
	logic signed [POS_W-1:0]  px_q, py_q, pz_q;
	logic                     out_valid_q;
	prim_item_t               out_q, out_d;

	mac_op_t                  op;
	mac_rnd_t                 rnd;
	mac_sum_t                 sum;

	logic [TW-1:0]            trig_n;
	logic signed [TRIG_W-1:0] trig_b;
	logic signed [MA_W-1:0]   radius_ext;
	logic                     accept, out_ld, emit_v, emit_t;
	logic                     ring_north, ring_cap1, ring_south, ring_band;
	logic                     last_vtx, last_tri;
	logic [IDX_W-1:0]         cur_j, cur_jn, prev_j, prev_jn;

	uvs_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.rnd    (rnd),
		.sum    (sum)
	);

	assign sphere_stall = (state_q != ST_IDLE);
	assign accept = sphere_valid && !sphere_stall;
	assign out_ld = !out_valid_q || !prim_stall;

	assign ring_north = (in_q.ring == RING_W'(0));
	assign ring_cap1 = (in_q.ring == RING_W'(1));
	assign ring_south = (in_q.ring == RING_W'(L));
	assign ring_band = !ring_north && !ring_cap1 && !ring_south;

	assign last_vtx = ring_north || ring_south || (j_q == JW'(L - 1));
	assign last_tri = (j_q == JW'(L - 1)) && (!ring_band || half_q);

	assign radius_ext = {{(MA_W-RADIUS_W){1'b0}}, in_q.sphere_radius};
	assign jn = (j_q == JW'(L - 1)) ? '0 : j_q + JW'(1);

	always_comb begin
		case (state_q)
			ST_MUL_ST: trig_n = TW'(in_q.ring) << 1;
			ST_MUL_CT: trig_n = (TW'(in_q.ring) << 1) + TW'(L);
			ST_MUL_Z:  trig_n = TW'(j_q) << 2;
			default:   trig_n = (TW'(j_q) << 2) + TW'(L);
		endcase
	end

	assign trig_b = trig_q14(trig_n);

	always_comb begin
		state_d = state_q;
		op = '0;
		emit_v = 1'b0;
		emit_t = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (sphere_valid && sphere.ring <= RING_W'(L)) state_d = ST_MUL_ST;
			end
			ST_MUL_ST: begin
				op.valid = 1'b1;
				op.tag = TAG_RS;
				op.sh = SH_NONE;
				op.a = radius_ext;
				op.b = trig_b;
				state_d = ST_MUL_CT;
			end
			ST_MUL_CT: begin
				op.valid = 1'b1;
				op.tag = TAG_PY;
				op.sh = SH_TRIG;
				op.a = radius_ext;
				op.b = trig_b;
				op.c = in_q.center_y;
				state_d = ST_WAIT_HDR;
			end
			ST_WAIT_HDR: begin
				if (sum.valid && sum.tag == TAG_PY) state_d = ST_MUL_X;
			end
			ST_MUL_X: begin
				op.valid = 1'b1;
				op.tag = TAG_PX;
				op.sh = SH_TRIG2;
				op.a = rs_q;
				op.b = trig_b;
				op.c = in_q.center_x;
				state_d = ST_MUL_Z;
			end
			ST_MUL_Z: begin
				op.valid = 1'b1;
				op.tag = TAG_PZ;
				op.sh = SH_TRIG2;
				op.a = rs_q;
				op.b = trig_b;
				op.c = in_q.center_z;
				state_d = ST_WAIT_V;
			end
			ST_WAIT_V: begin
				if (sum.valid && sum.tag == TAG_PZ) state_d = ST_EMIT_V;
			end
			ST_EMIT_V: begin
				if (out_ld) begin
					emit_v = 1'b1;
					if (!last_vtx) state_d = ST_MUL_X;
					else if (ring_north) state_d = ST_IDLE;
					else state_d = ST_TRI;
				end
			end
			ST_TRI: begin
				if (out_ld) begin
					emit_t = 1'b1;
					if (last_tri) state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			j_q <= '0;
			half_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				j_q <= '0;
				half_q <= 1'b0;
			end else if (emit_v) begin
				j_q <= last_vtx ? '0 : j_q + JW'(1);
			end else if (emit_t) begin
				if (ring_band && !half_q) begin
					half_q <= 1'b1;
				end else begin
					half_q <= 1'b0;
					j_q <= jn;
				end
			end
			if (out_ld) out_valid_q <= emit_v || emit_t;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) in_q <= sphere;
		if (state_q == ST_MUL_ST) begin
			cur_q <= in_q.base_vertex + IDX_W'(1)
			       + (IDX_W'(in_q.ring) - IDX_W'(1)) * IDX_W'(L);
		end
		if (state_q == ST_MUL_CT) prev_q <= cur_q - IDX_W'(L);
		if (rnd.valid && rnd.tag == TAG_RS) rs_q <= rnd.value;
		if (sum.valid) begin
			case (sum.tag)
				TAG_PY:  py_q <= sum.value;
				TAG_PX:  px_q <= sum.value;
				TAG_PZ:  pz_q <= sum.value;
				default: ;
			endcase
		end
		if (out_ld && (emit_v || emit_t)) out_q <= out_d;
	end

	assign cur_j = cur_q + IDX_W'(j_q);
	assign cur_jn = cur_q + IDX_W'(jn);
	assign prev_j = prev_q + IDX_W'(j_q);
	assign prev_jn = prev_q + IDX_W'(jn);

	always_comb begin
		out_d = '0;
		if (emit_v) begin
			out_d.item_kind = KIND_VERTEX;
			out_d.pos_x = px_q;
			out_d.pos_y = py_q;
			out_d.pos_z = pz_q;
			out_d.out_red = in_q.color_red;
			out_d.out_green = in_q.color_green;
			out_d.out_blue = in_q.color_blue;
			out_d.last = ring_north;
		end else begin
			out_d.item_kind = KIND_TRI;
			out_d.last = last_tri;
			if (ring_cap1) begin
				out_d.index_a = in_q.base_vertex;
				out_d.index_b = cur_jn;
				out_d.index_c = cur_j;
			end else if (ring_south) begin
				// cur_q is the south pole here, prev_q the last middle row
				out_d.index_a = cur_q;
				out_d.index_b = prev_j;
				out_d.index_c = prev_jn;
			end else if (!half_q) begin
				out_d.index_a = prev_j;
				out_d.index_b = prev_jn;
				out_d.index_c = cur_j;
			end else begin
				out_d.index_a = prev_jn;
				out_d.index_b = cur_jn;
				out_d.index_c = cur_j;
			end
		end
	end

	assign prim_valid = out_valid_q;
	assign prim = out_q;

	a_start_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && sphere.ring <= RING_W'(L)) |=> (state_q == ST_MUL_ST))
		else $error("in-range item accepted but sequencer did not start");

	a_unit_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_TRI) |-> (!sum.valid && !rnd.valid))
		else $error("shared unit still busy outside vertex work");

	a_busy_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sphere_stall) |-> $past(sphere_valid))
		else $error("block went busy without an accepted item");

	a_vertex_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WAIT_V && sum.valid) |-> (sum.tag == TAG_PX || sum.tag == TAG_PZ))
		else $error("unexpected result tag while waiting on vertex products");

endmodule

`default_nettype wire
